FILE: sv/fxalu_pkg.sv
// fxalu_pkg: types, operation codes and constants for the q24.8 fixed-point alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fxalu_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits = 8;
  localparam int QueueDepth = 4;
  localparam int QueueAw = 2;
  // magnitude of the dividend: 32-bit magnitude shifted by the fraction bits
  localparam int NumWidth = DataWidth + FracBits;
  localparam int CntWidth = 6;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_EQ = 4'd6, OP_GE = 4'd7,
    OP_LE = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  typedef struct packed {
    logic [3:0] operation;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_raw;
    logic condition;
    logic overflow;
    logic divide_by_zero;
  } out_item_t;

  // work class decided by the front end
  typedef enum logic [1:0] {
    CLS_DONE = 2'd0,
    CLS_MUL = 2'd1,
    CLS_DIV = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic neg;
    logic [DataWidth-1:0] mag_a;
    logic [DataWidth-1:0] mag_b;
    out_item_t done;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL = 2'd1,
    ST_DIV = 2'd2,
    ST_FIN = 2'd3
  } back_state_t;

  function automatic logic [DataWidth-1:0] sat32(input logic neg,
                                                 input logic [NumWidth:0] mag,
                                                 output logic ovf);
    logic [NumWidth:0] lim;
    logic [DataWidth-1:0] res;
    begin
      lim = {{(NumWidth-DataWidth+1){1'b0}}, 1'b1, {(DataWidth-1){1'b0}}};
      ovf = 1'b0;
      if (neg) begin
        if (mag > lim) begin
          ovf = 1'b1;
          res = {1'b1, {(DataWidth-1){1'b0}}};
        end else begin
          res = -mag[DataWidth-1:0];
        end
      end else begin
        if (mag >= lim) begin
          ovf = 1'b1;
          res = {1'b0, {(DataWidth-1){1'b1}}};
        end else begin
          res = mag[DataWidth-1:0];
        end
      end
      sat32 = res;
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/fxalu_front.sv
// fxalu_front: decodes an item, finishes operations other than multiply and divide, and
// prepares sign and magnitudes for multiply and divide; uses fxalu_pkg
`timescale 1ns / 1ps
`default_nettype none
module fxalu_front import fxalu_pkg::*; (
  input  wire in_item_t item,
  output job_t         job
);

  logic signed [DataWidth-1:0] a;
  logic signed [DataWidth-1:0] b;
  logic [DataWidth-1:0] ua;
  logic [DataWidth-1:0] ub;
  logic lt;
  logic eq;

  always_comb begin
    a = item.operand_a;
    b = item.operand_b;
    ua = a;
    ub = b;
    lt = a < b;
    eq = a == b;
    job = '0;
    job.cls = CLS_DONE;
    job.neg = a[DataWidth-1] ^ b[DataWidth-1];
    job.mag_a = a[DataWidth-1] ? -ua : ua;
    job.mag_b = b[DataWidth-1] ? -ub : ub;
    case (op_t'(item.operation))
      OP_ADD: job.done.result_raw = ua + ub;
      OP_SUB: job.done.result_raw = ua - ub;
      OP_MUL: job.cls = CLS_MUL;
      OP_DIV: begin
        if (ub == '0) job.done.divide_by_zero = 1'b1;
        else job.cls = CLS_DIV;
      end
      OP_GT: job.done.condition = !lt && !eq;
      OP_LT: job.done.condition = lt;
      OP_EQ: job.done.condition = eq;
      OP_GE: job.done.condition = !lt;
      OP_LE: job.done.condition = lt || eq;
      OP_NE: job.done.condition = !eq;
      OP_MIN: job.done.result_raw = lt ? ua : ub;
      OP_MAX: job.done.result_raw = (!lt && !eq) ? ua : ub;
      OP_INC: job.done.result_raw = ua + 1'b1;
      OP_DEC: job.done.result_raw = ua - 1'b1;
      OP_FROM_INT: job.done.result_raw = ua << FracBits;
      OP_TO_INT: job.done.result_raw = a >>> FracBits;
      default: job.done = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/fxalu_queue.sv
// fxalu_queue: short fifo of classified jobs between front and back
// uses fxalu_pkg
`timescale 1ns / 1ps
`default_nettype none
module fxalu_queue import fxalu_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  wire job_t  push_job,
  input  wire        pop,
  output job_t       head,
  output logic       empty,
  output logic       full
);

  job_t mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0] count;

  assign empty = count == '0;
  assign full = count == (QueueAw+1)'(QueueDepth);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: sv/fxalu_back.sv
// fxalu_back: carries out queued jobs; multiply in two 32x16 partial products,
// divide by restoring shift-subtract one bit a cycle; uses fxalu_pkg
`timescale 1ns / 1ps
`default_nettype none
module fxalu_back import fxalu_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        avail,
  input  wire job_t  job,
  output logic       pop,
  output logic       res_valid,
  output out_item_t  res
);

  localparam int Half = DataWidth / 2;
  localparam int ProdWidth = 2 * DataWidth;

  back_state_t state;
  back_state_t state_next;
  logic neg;
  logic [DataWidth-1:0] ma;
  logic [DataWidth-1:0] mb;
  logic [ProdWidth-1:0] prod;
  logic step;
  logic [NumWidth-1:0] num;
  logic [NumWidth:0] rem;
  logic [CntWidth-1:0] cnt;
  logic [NumWidth:0] trial;
  logic [DataWidth+Half-1:0] pp_half;
  logic [ProdWidth-1:0] pp;

  assign trial = {rem[NumWidth-1:0], num[NumWidth-1]} - {1'b0, {(NumWidth-DataWidth){1'b0}}, mb};
  assign pp_half = ma * mb[step*Half +: Half];
  assign pp = ProdWidth'(pp_half);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_FIN: begin
        state_next = ST_IDLE;
        if (avail) begin
          case (job.cls)
            CLS_MUL: state_next = ST_MUL;
            CLS_DIV: state_next = ST_DIV;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL: if (step) state_next = ST_FIN;
      ST_DIV: if (cnt == CntWidth'(NumWidth - 1)) state_next = ST_FIN;
      default: state_next = ST_IDLE;
    endcase
  end

  // the finish state owns the result register, so a finished job at the head waits there for the idle state
  always_comb begin
    pop = avail && (state == ST_IDLE || (state == ST_FIN && job.cls != CLS_DONE));
  end

  logic is_div;
  logic [NumWidth:0] div_q;
  logic [NumWidth:0] mul_q;
  logic [NumWidth:0] fin_mag;
  logic fin_ovf;
  logic [DataWidth-1:0] fin_res;
  logic [ProdWidth-FracBits:0] mul_full;

  always_comb begin
    mul_full = ((ProdWidth-FracBits+1)'(prod >> (FracBits-1)) + 1'b1) >> 1;
    mul_q = (|mul_full[ProdWidth-FracBits:NumWidth]) ? '1 : mul_full[NumWidth:0];
    div_q = {1'b0, num} + (NumWidth+1)'(({rem[NumWidth-1:0], 1'b0} >= {1'b0, mb}) ? 1 : 0);
    fin_mag = is_div ? div_q : mul_q;
    fin_res = sat32(neg, fin_mag, fin_ovf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      res_valid <= (pop && job.cls == CLS_DONE) || state == ST_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      res.result_raw <= fin_res;
      res.condition <= 1'b0;
      res.overflow <= fin_ovf;
      res.divide_by_zero <= 1'b0;
    end else if (pop) begin
      res <= job.done;
    end
    if (pop) begin
      neg <= job.neg;
      ma <= job.mag_a;
      mb <= job.mag_b;
      prod <= '0;
      step <= 1'b0;
      num <= {job.mag_a, {FracBits{1'b0}}};
      rem <= '0;
      cnt <= '0;
      is_div <= job.cls == CLS_DIV;
    end else if (state == ST_MUL) begin
      prod <= prod + (step ? (pp << Half) : pp);
      step <= 1'b1;
    end else if (state == ST_DIV) begin
      if (!trial[NumWidth]) begin
        rem <= trial;
        num <= {num[NumWidth-2:0], 1'b1};
      end else begin
        rem <= {rem[NumWidth-1:0], num[NumWidth-1]};
        num <= {num[NumWidth-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: sv/fixed_point_q24_8_alu.sv
// fixed_point_q24_8_alu: q24.8 fixed-point alu top level
// uses fxalu_pkg, fxalu_front, fxalu_queue, fxalu_back
`timescale 1ns / 1ps
`default_nettype none
// Operations other than multiply and divide finish in the front end and
// stream one beat per cycle while the back end is idle, passing the queue
// and the result register on the way to done. Multiply runs in the back end
// as two 32x16 partial products and divide as one quotient bit per cycle over
// 40 bits; an operation of the first kind right behind either waits out the
// finish state. A four-entry queue takes items while the back end works, and
// busy rises when it is full.
// Each result is shown for one cycle under done; the receiver cannot stall.
module fixed_point_q24_8_alu import fxalu_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       start,
  input  wire in_item_t in_item,
  output logic      busy,
  output logic      done,
  output out_item_t out_item
);

  job_t front_job;
  job_t head;
  logic empty;
  logic full;
  logic pop;

  fxalu_front u_front (.item(in_item), .job(front_job));

  fxalu_queue u_queue (
    .clk(clk), .rst(rst), .push(start && !busy), .push_job(front_job),
    .pop(pop), .head(head), .empty(empty), .full(full)
  );

  fxalu_back u_back (
    .clk(clk), .rst(rst), .avail(!empty), .job(head), .pop(pop),
    .res_valid(done), .res(out_item)
  );

  assign busy = full;

endmodule
`default_nettype wire

FILE: dv/fixed_point_q24_8_alu_tb.sv
// fixed_point_q24_8_alu_tb: self-checking testbench for the q24.8 fixed-point alu
// directed corner beats then random operations, each result checked against a local predictor
// depends on fxalu_pkg and fixed_point_q24_8_alu
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_tb;
  import fxalu_pkg::*;

  localparam int NumRandom = 1750;
  localparam int CycleLimit = 400000;
  localparam int Frac = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t in_item = '0;
  logic busy;
  logic done;
  out_item_t out_item;

  in_item_t pending_ops[$];
  out_item_t alu_results_due[$];
  int mismatches = 0;
  int unexpected = 0;
  int results_seen = 0;
  int cycles = 0;
  int idle_left = 0;
  bit stimulus_done = 1'b0;
  bit quiet_phase = 1'b0;
  int op_count[16];

  fixed_point_q24_8_alu dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .out_item(out_item)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] clamp_signed(bit neg, logic [63:0] mag, output bit ovf);
    ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  function automatic out_item_t alu_predict(in_item_t it);
    out_item_t r;
    logic signed [31:0] a, b;
    logic [63:0] ma, mb, prod, num, q, rem;
    bit neg, ovf;
    r = '0;
    a = it.operand_a;
    b = it.operand_b;
    ma = a[31] ? 64'd0 - {{32{a[31]}}, a} : {32'd0, a};
    mb = b[31] ? 64'd0 - {{32{b[31]}}, b} : {32'd0, b};
    neg = a[31] != b[31];
    case (op_t'(it.operation))
      OP_ADD: r.result_raw = a + b;
      OP_SUB: r.result_raw = a - b;
      OP_MUL: begin
        prod = (ma * mb + 64'd128) >> Frac;
        r.result_raw = clamp_signed(neg, prod, ovf);
        r.overflow = ovf;
      end
      OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          num = ma << Frac;
          q = num / mb;
          rem = num % mb;
          if (rem >= mb - rem) q = q + 1;
          r.result_raw = clamp_signed(neg, q, ovf);
          r.overflow = ovf;
        end
      end
      OP_GT: r.condition = a > b;
      OP_LT: r.condition = a < b;
      OP_EQ: r.condition = a == b;
      OP_GE: r.condition = a >= b;
      OP_LE: r.condition = a <= b;
      OP_NE: r.condition = a != b;
      OP_MIN: r.result_raw = (a < b) ? a : b;
      OP_MAX: r.result_raw = (a > b) ? a : b;
      OP_INC: r.result_raw = a + 1;
      OP_DEC: r.result_raw = a - 1;
      OP_FROM_INT: r.result_raw = a <<< Frac;
      default: r.result_raw = a >>> Frac;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3: return 32'($signed($urandom_range(0, 4095)) - 2048);
      4: return 32'($signed($urandom_range(0, 32'h1FFFF)) - 32'h10000);
      5: return {24'($signed($urandom_range(0, 64)) - 32), 8'h80};
      default: return $urandom();
    endcase
  endfunction

  task automatic add_op(op_t op, logic [31:0] a, logic [31:0] b);
    in_item_t it;
    it.operation = op;
    it.operand_a = a;
    it.operand_b = b;
    pending_ops.push_back(it);
  endtask

  // acceptance and prediction at posedge, next-beat selection and drive at negedge
  bit take_now;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    take_now = !rst && start && !busy;
    if (take_now) begin
      alu_results_due.push_back(alu_predict(in_item));
      op_count[in_item.operation] <= op_count[in_item.operation] + 1;
    end
    if (done) begin
      results_seen <= results_seen + 1;
      if (alu_results_due.size() == 0) begin
        unexpected <= unexpected + 1;
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", out_item);
      end else begin
        out_item_t e;
        e = alu_results_due.pop_front();
        if (out_item !== e) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp raw=%h c=%b o=%b z=%b got raw=%h c=%b o=%b z=%b",
                     e.result_raw, e.condition, e.overflow, e.divide_by_zero,
                     out_item.result_raw, out_item.condition, out_item.overflow,
                     out_item.divide_by_zero);
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || take_now) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        if (!quiet_phase && pending_ops.size() > 200 && $urandom_range(0, 9) == 0) begin
          idle_left <= $urandom_range(0, 11);
          start <= 1'b0;
        end else begin
          in_item <= pending_ops.pop_front();
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    logic [31:0] ext[8];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF,
            32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0080};
    for (int i = 0; i < 16; i++) op_count[i] = 0;
    // directed: every operation on extremes
    for (int o = 0; o < 16; o++) add_op(op_t'(o), ext[o % 8], ext[(o + 3) % 8]);
    add_op(OP_DIV, 32'h0000_0500, 32'h0);
    add_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
    add_op(OP_MUL, 32'h8000_0000, 32'h0000_0100);
    add_op(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_op(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
    add_op(OP_DIV, 32'h0000_0001, 32'h0000_0200);
    add_op(OP_MIN, 32'h1234_5678, 32'h1234_5678);
    add_op(OP_TO_INT, 32'hFFFF_FF01, 32'h0);
    add_op(OP_FROM_INT, 32'h00FF_FFFF, 32'h0);
    for (int n = 0; n < NumRandom; n++) begin
      logic [31:0] a, b;
      a = pick_operand();
      b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
      add_op(op_t'($urandom_range(0, 15)), a, b);
    end
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (pending_ops.size() < 150);
    quiet_phase = 1'b1;
    wait (pending_ops.size() == 0 && !start);
    wait (alu_results_due.size() == 0);
    repeat (60) @(posedge clk);
    $display("%0d results checked over all 16 operations, %0d divides, %0d multiplies",
             results_seen, op_count[OP_DIV], op_count[OP_MUL]);
    if (mismatches == 0 && alu_results_due.size() == 0)
      $display("fixed_point_q24_8_alu_tb passed");
    else
      $display("fixed_point_q24_8_alu_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("fixed_point_q24_8_alu_tb failed");
      $finish;
    end
  end

endmodule
